@@ hw/rtl/qesm_pkg.sv @@
// Shared constants and types for the quadrature encoder speed meter.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package qesm_pkg;

    localparam int RING_DEPTH  = 8;
    localparam int INTERVAL_W  = 17;
    localparam int SUM_W       = INTERVAL_W + $clog2(RING_DEPTH);
    localparam int SLOT_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FRAC_BITS   = 16;
    localparam int DIST_W      = 24;
    localparam int POS_W       = 32;
    localparam int TIME_W      = 32;
    localparam int SPEED_W     = 24;

    // speed = SPEED_SCALE * RING_DEPTH / ring sum
    localparam int SPEED_SCALE = 2000000;
    localparam int SPEED_NUM   = SPEED_SCALE * RING_DEPTH;
    localparam int NUM_W       = $clog2(SPEED_NUM + 1);
    localparam int CNT_W       = $clog2(NUM_W);
    localparam logic [NUM_W-1:0] SPEED_NUM_V = NUM_W'(SPEED_NUM);
    localparam logic [31:0] SPEED_MAX = 32'h00FF_FFFF;

    localparam logic [INTERVAL_W-1:0] STALE_RESET = INTERVAL_W'(100000);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REVERSED       = 2'd0,
        CFG_COUNT_DISTANCE = 2'd1,
        CFG_STALE_LIMIT    = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic capture;
        logic update;
        logic div_step;
        logic load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic need_div;
        logic div_last;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

@@ hw/rtl/qesm_if.sv @@
// Handshake channel interfaces: encoder edge in, result out, register writes.
// Depends on qesm_pkg for field widths.
`default_nettype none

interface qesm_in_if;
    import qesm_pkg::*;
    logic              valid;
    logic              ready;
    logic              a_level;
    logic              b_level;
    logic [TIME_W-1:0] time_us;
    logic              turning_on_spot;

    modport source (output valid, a_level, b_level, time_us, turning_on_spot, input ready);
    modport sink   (input valid, a_level, b_level, time_us, turning_on_spot, output ready);
endinterface

interface qesm_out_if;
    import qesm_pkg::*;
    logic               valid;
    logic               ready;
    logic [POS_W-1:0]   position;
    logic [31:0]        total_mm;
    logic [SPEED_W-1:0] speed;
    logic               interval_taken;

    modport source (output valid, position, total_mm, speed, interval_taken, input ready);
    modport sink   (input valid, position, total_mm, speed, interval_taken, output ready);
endinterface

interface qesm_cfg_if;
    import qesm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/qesm_ctrl.sv @@
// Sequencing controller: accept, update, iterative divide, result load.
// Depends on qesm_pkg for command and status structs.
`default_nettype none

module qesm_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire qesm_pkg::t_dp_status i_sts,
    output qesm_pkg::t_ctrl_cmd      o_cmd
);
    import qesm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_UPDATE = 4'b0010,
        S_DIV    = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_in_ready     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = i_sts.need_div ? S_DIV : S_DONE;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register frees up
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_sts.out_free)
        else $error("result loaded into a full output register");

    a_capture_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == S_UPDATE))
        else $error("captured edge not followed by update");

    a_div_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.div_step && i_sts.div_last) |=> (r_state == S_DONE))
        else $error("divide did not finish into result stage");

    a_done_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && i_sts.out_free) |=> (r_state == S_IDLE && o_in_ready))
        else $error("controller did not return to accept after load");

endmodule

`default_nettype wire

@@ hw/rtl/qesm_dp.sv @@
// Datapath: config registers, position and distance update, interval ring,
// restoring divider and output register. Depends on qesm_pkg.
`default_nettype none

module qesm_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire qesm_pkg::t_ctrl_cmd           i_cmd,
    output qesm_pkg::t_dp_status               o_sts,
    input  wire logic                          i_cfg_we,
    input  wire logic [qesm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [qesm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                          i_a_level,
    input  wire logic                          i_b_level,
    input  wire logic [qesm_pkg::TIME_W-1:0]   i_time_us,
    input  wire logic                          i_turning,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic [qesm_pkg::POS_W-1:0]         o_position,
    output logic [31:0]                        o_total_mm,
    output logic [qesm_pkg::SPEED_W-1:0]       o_speed,
    output logic                               o_interval_taken
);
    import qesm_pkg::*;

    // configuration
    logic                  r_rev;
    logic [DIST_W-1:0]     r_count_dist;
    logic [INTERVAL_W-1:0] r_stale;

    // captured edge
    logic              r_a, r_b, r_turn;
    logic [TIME_W-1:0] r_time;

    // measurement state
    logic [POS_W-1:0]      r_pos, n_pos;
    logic                  r_last_b;
    logic [FRAC_BITS-1:0]  r_frac;
    logic [31:0]           r_mm;
    logic [TIME_W-1:0]     r_last_time;
    logic [INTERVAL_W-1:0] r_ring [RING_DEPTH];
    logic [SLOT_W-1:0]     r_slot;
    logic [SUM_W-1:0]      r_sum, n_sum;
    logic [SPEED_W-1:0]    r_speed;
    logic                  r_taken;

    // divider
    logic [SUM_W-1:0] r_div, r_rem, n_rem;
    logic [NUM_W-1:0] r_quot, n_quot;
    logic [CNT_W-1:0] r_cnt;
    logic [SUM_W:0]   div_trial;
    logic             div_ge;

    // output register
    logic               r_out_valid;
    logic [POS_W-1:0]   r_out_pos;
    logic [31:0]        r_out_mm;
    logic [SPEED_W-1:0] r_out_speed;
    logic               r_out_taken;

    logic                  up1, up2, moved;
    logic [DIST_W:0]       dist_acc;
    logic [TIME_W-1:0]     elapsed;
    logic                  take;

    always_comb begin
        up1      = (r_a != r_last_b) ^ r_rev;
        up2      = (r_a == r_b) ^ r_rev;
        moved    = (up1 == up2);
        n_pos    = r_pos;
        if (up1 && up2) begin
            n_pos = r_pos + POS_W'(2);
        end else if (!up1 && !up2) begin
            n_pos = r_pos - POS_W'(2);
        end
        dist_acc = {{(DIST_W - FRAC_BITS + 1){1'b0}}, r_frac} + {1'b0, r_count_dist};
        elapsed  = r_time - r_last_time;
        take     = !elapsed[TIME_W-1]
                   && (elapsed <= {{(TIME_W - INTERVAL_W){1'b0}}, r_stale});
        n_sum    = r_sum - SUM_W'(r_ring[r_slot]) + SUM_W'(elapsed[INTERVAL_W-1:0]);
    end

    always_comb begin
        div_trial = {r_rem, SPEED_NUM_V[r_cnt]};
        div_ge    = (div_trial >= {1'b0, r_div});
        n_rem     = div_ge ? SUM_W'(div_trial - {1'b0, r_div}) : SUM_W'(div_trial);
        n_quot    = {r_quot[NUM_W-2:0], div_ge};
    end

    assign o_sts.need_div = take && (n_sum != '0);
    assign o_sts.div_last = (r_cnt == '0);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rev        <= 1'b0;
            r_count_dist <= '0;
            r_stale      <= STALE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_REVERSED:       r_rev        <= i_cfg_data[0];
                CFG_COUNT_DISTANCE: r_count_dist <= i_cfg_data[DIST_W-1:0];
                CFG_STALE_LIMIT:    r_stale      <= i_cfg_data[INTERVAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_a    <= i_a_level;
            r_b    <= i_b_level;
            r_time <= i_time_us;
            r_turn <= i_turning;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_last_b    <= 1'b0;
            r_frac      <= '0;
            r_mm        <= '0;
            r_last_time <= '0;
            r_slot      <= '0;
            r_sum       <= '0;
            r_speed     <= '0;
            r_taken     <= 1'b0;
            for (int i = 0; i < RING_DEPTH; i++) begin
                r_ring[i] <= '0;
            end
        end else begin
            if (i_cmd.update) begin
                r_pos       <= n_pos;
                r_last_b    <= r_b;
                r_last_time <= r_time;
                r_taken     <= take;
                if (moved && !r_turn) begin
                    r_frac <= dist_acc[FRAC_BITS-1:0];
                    r_mm   <= r_mm + 32'(dist_acc[DIST_W:FRAC_BITS]);
                end
                if (take) begin
                    r_ring[r_slot] <= elapsed[INTERVAL_W-1:0];
                    r_sum          <= n_sum;
                    r_slot         <= (r_slot == SLOT_W'(RING_DEPTH - 1))
                                      ? '0 : r_slot + SLOT_W'(1);
                end
            end
            if (i_cmd.div_step && o_sts.div_last) begin
                // saturate the finished quotient
                r_speed <= (32'(n_quot) > SPEED_MAX) ? SPEED_W'(SPEED_MAX)
                                                     : SPEED_W'(n_quot);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_div  <= n_sum;
            r_rem  <= '0;
            r_quot <= '0;
            r_cnt  <= CNT_W'(NUM_W - 1);
        end else if (i_cmd.div_step) begin
            r_rem  <= n_rem;
            r_quot <= n_quot;
            r_cnt  <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_pos   <= r_pos;
            r_out_mm    <= r_mm;
            r_out_speed <= r_speed;
            r_out_taken <= r_taken;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_position       = r_out_pos;
    assign o_total_mm       = r_out_mm;
    assign o_speed          = r_out_speed;
    assign o_interval_taken = r_out_taken;

endmodule

`default_nettype wire

@@ hw/rtl/quadrature_encoder_speed_meter.sv @@
// Quadrature encoder speed meter, top level.
// Usage:
//   i_edge   : one beat per edge on encoder channel A (levels, timestamp,
//              turning flag). Only one edge is in flight at a time.
//   o_result : one beat per edge: position, whole millimetres, speed in
//              counts per second, and whether the interval entered the ring.
//   i_cfg    : register writes (reversed, count_distance, stale_limit_us),
//              always ready; write only while the block is idle.
// Sequence: an accepted edge is captured and then updated; when its interval
//   is taken and the new ring sum is nonzero, the restoring divider then
//   builds the NUM_W-bit quotient, NUM_W being the bit width of 2e6 * ring
//   depth, one quotient bit a cycle; the result stage then loads o_result.
// Accept: a new edge is taken only once the result of the last one has
//   been loaded into the output register.
// Output register: the next edge is accepted while a result waits; a
//   stalled sink holds the block in its result stage before the next load.
// Reset: position, distance, last timestamp, interval ring and speed clear to
//   zero, stale_limit_us returns to 100000; no clearing pass is needed.
// Depends on qesm_pkg, qesm_if, qesm_ctrl and qesm_dp.
`default_nettype none

module quadrature_encoder_speed_meter (
    input wire logic   i_clk,
    input wire logic   i_rst_n,
    qesm_in_if.sink    i_edge,
    qesm_cfg_if.sink   i_cfg,
    qesm_out_if.source o_result
);
    import qesm_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status sts;
    logic       in_ready;

    assign i_edge.ready = in_ready;
    assign i_cfg.ready  = 1'b1;

    qesm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_edge.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    qesm_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_we         (i_cfg.valid),
        .i_cfg_idx        (i_cfg.index),
        .i_cfg_data       (i_cfg.data),
        .i_a_level        (i_edge.a_level),
        .i_b_level        (i_edge.b_level),
        .i_time_us        (i_edge.time_us),
        .i_turning        (i_edge.turning_on_spot),
        .i_out_ready      (o_result.ready),
        .o_out_valid      (o_result.valid),
        .o_position       (o_result.position),
        .o_total_mm       (o_result.total_mm),
        .o_speed          (o_result.speed),
        .o_interval_taken (o_result.interval_taken)
    );

endmodule

`default_nettype wire
